@@ hw/rtl/fat16_cluster_chain_table_unit_macros.svh @@
// Assertion macros for the cluster chain table unit.
`ifndef FAT16_CLUSTER_CHAIN_TABLE_UNIT_MACROS_SVH
`define FAT16_CLUSTER_CHAIN_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define FAT16CCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FAT16CCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/fat16cct_pkg.sv @@
// Shared types, codes and constants of the cluster chain table unit.
package fat16cct_pkg;

   localparam int OP_W      = 3;
   localparam int CLUSTER_W = 16;
   localparam int LINK_W    = 16;
   localparam int COUNT_W   = 7;
   localparam int FREED_W   = 10;
   localparam int STATUS_W  = 3;

   localparam int NUM_CLUSTERS_DEF = 4096;
   localparam int FREE_LIMIT_DEF   = 1000;
   localparam int MAX_CHAIN_DEF    = 100;

   localparam logic [OP_W-1:0] OP_READ_NEXT   = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_ENTRY   = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND_FREE   = 3'd2;
   localparam logic [OP_W-1:0] OP_FREE_CHAIN  = 3'd3;
   localparam logic [OP_W-1:0] OP_ALLOC_CHAIN = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OUT      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOOP     = 3'd4;

   localparam logic [LINK_W-1:0] LINK_FREE     = 16'h0000;
   localparam logic [LINK_W-1:0] LINK_END      = 16'hFFFF;
   localparam logic [LINK_W-1:0] RESERVED_FROM = 16'hFFF0;
   localparam logic [LINK_W-1:0] END_FROM      = 16'hFFF8;

   typedef struct packed {
      logic                 en;
      logic [CLUSTER_W-1:0] addr;
      logic [LINK_W-1:0]    data;
   } ram_wr_type;

endpackage

@@ hw/rtl/fat16_cluster_chain_table_unit.sv @@
// Top level of the FAT16 cluster chain table unit: sequencer around the link memory.
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   request | req_valid/req_ready, req_*    | in
//   result  | rsp_valid/rsp_ready, rsp_*    | out
//
// After reset a clearing pass writes zero to every entry, with req_ready low.
// find_free scans the table with one memory read per cycle on the single read port.
// alloc_chain scans twice. free_chain reads, then clears, each cluster of the chain in turn.
// One request at a time; the result register holds while rsp_ready is low and a new
// request is taken meanwhile.
module fat16_cluster_chain_table_unit #(
   parameter int NUM_CLUSTERS = fat16cct_pkg::NUM_CLUSTERS_DEF,
   parameter int FREE_LIMIT   = fat16cct_pkg::FREE_LIMIT_DEF,
   parameter int MAX_CHAIN    = fat16cct_pkg::MAX_CHAIN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fat16cct_pkg::OP_W-1:0]       req_operation,
   input  logic [fat16cct_pkg::CLUSTER_W-1:0]  req_cluster,
   input  logic [fat16cct_pkg::LINK_W-1:0]     req_link_value,
   input  logic [fat16cct_pkg::COUNT_W-1:0]    req_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fat16cct_pkg::CLUSTER_W-1:0]  rsp_result_value,
   output logic [fat16cct_pkg::FREED_W-1:0]    rsp_freed_count,
   output logic [fat16cct_pkg::STATUS_W-1:0]   rsp_status
);
   import fat16cct_pkg::*;

   localparam int AW  = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
   localparam int SW  = $clog2(NUM_CLUSTERS + 1);
   localparam int FCW = ($clog2(FREE_LIMIT + 2) > FREED_W) ? $clog2(FREE_LIMIT + 2) : FREED_W;

   typedef enum logic [7:0] {
      S_CLEAR   = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_READ    = 8'b0000_0100,
      S_SCAN    = 8'b0000_1000,
      S_WALK_RD = 8'b0001_0000,
      S_WALK_WR = 8'b0010_0000,
      S_END_WR  = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [SW-1:0]        clr_addr_ff, clr_addr_in;
   logic [SW-1:0]        scan_addr_ff, scan_addr_in;
   logic                 chk_ff, chk_in;
   logic                 scan_alloc_ff, scan_alloc_in;
   logic                 pass2_ff, pass2_in;
   logic [COUNT_W-1:0]   need_ff, need_in;
   logic [COUNT_W-1:0]   got_ff, got_in;
   logic [SW-1:0]        first_ff, first_in;
   logic [SW-1:0]        prev_ff, prev_in;
   logic [CLUSTER_W-1:0] cur_ff, cur_in;
   logic [FCW-1:0]       freed_ff, freed_in;
   logic [CLUSTER_W-1:0] res_value_ff, res_value_in;
   logic [FREED_W-1:0]   res_freed_ff, res_freed_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CLUSTER_W-1:0] rsp_value_ff, rsp_value_in;
   logic [FREED_W-1:0]   rsp_freed_ff, rsp_freed_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   ram_wr_type        ram_wr;
   logic [AW-1:0]     ram_rd_addr;
   logic [LINK_W-1:0] ram_rd_data;

   logic                 req_fire;
   logic                 out_free;
   logic                 cl_reserved;
   logic                 cl_beyond;
   logic [COUNT_W-1:0]   need_req;
   logic [SW-1:0]        cand;
   logic                 hit;
   logic                 more;
   logic                 exhausted;
   logic [COUNT_W-1:0]   got_nxt;
   logic [FCW-1:0]       freed_nxt;

   fat16cct_link_ram #(
      .DEPTH (NUM_CLUSTERS),
      .AW    (AW)
   ) u_link_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cl_reserved = (req_cluster < 16'd2);
   assign cl_beyond   = ({1'b0, req_cluster} >= 17'(NUM_CLUSTERS));
   assign need_req    = (req_count == '0) ? COUNT_W'(1) : req_count;

   // scan pipeline: rd data belongs to the address issued in the previous cycle
   assign cand      = scan_addr_ff - SW'(1);
   assign hit       = chk_ff && (ram_rd_data == LINK_FREE);
   assign more      = (scan_addr_ff != SW'(NUM_CLUSTERS));
   assign exhausted = !chk_ff && !more;
   assign got_nxt   = got_ff + COUNT_W'(1);
   assign freed_nxt = freed_ff + FCW'(1);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      scan_addr_in  = scan_addr_ff;
      chk_in        = chk_ff;
      scan_alloc_in = scan_alloc_ff;
      pass2_in      = pass2_ff;
      need_in       = need_ff;
      got_in        = got_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      freed_in      = freed_ff;
      res_value_in  = res_value_ff;
      res_freed_in  = res_freed_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr        = '0;
      ram_rd_addr   = '0;

      case (state_ff)
         S_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = CLUSTER_W'(clr_addr_ff);
            ram_wr.data = LINK_FREE;
            clr_addr_in = clr_addr_ff + SW'(1);
            if (clr_addr_ff == SW'(NUM_CLUSTERS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            ram_rd_addr = req_cluster[AW-1:0];
            if (req_fire) begin
               res_value_in  = '0;
               res_freed_in  = '0;
               res_status_in = ST_OK;
               state_in      = S_RESP;
               case (req_operation)
                  OP_READ_NEXT: begin
                     if (cl_reserved || req_cluster >= RESERVED_FROM) begin
                        res_value_in  = LINK_END;
                        res_status_in = ST_RESERVED;
                     end else if (cl_beyond) begin
                        res_value_in  = LINK_END;
                        res_status_in = ST_OUT;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  OP_SET_ENTRY: begin
                     if (cl_reserved) begin
                        res_status_in = ST_RESERVED;
                     end else if (cl_beyond) begin
                        res_status_in = ST_OUT;
                     end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = req_cluster;
                        ram_wr.data = req_link_value;
                     end
                  end
                  OP_FIND_FREE: begin
                     scan_addr_in  = SW'(2);
                     chk_in        = 1'b0;
                     scan_alloc_in = 1'b0;
                     pass2_in      = 1'b0;
                     state_in      = S_SCAN;
                  end
                  OP_FREE_CHAIN: begin
                     if (cl_reserved) begin
                        res_status_in = ST_RESERVED;
                     end else begin
                        cur_in   = req_cluster;
                        freed_in = '0;
                        state_in = S_WALK_RD;
                     end
                  end
                  OP_ALLOC_CHAIN: begin
                     if (int'(need_req) > MAX_CHAIN) begin
                        res_status_in = ST_NOSPACE;
                     end else begin
                        need_in       = need_req;
                        got_in        = '0;
                        scan_addr_in  = SW'(2);
                        chk_in        = 1'b0;
                        scan_alloc_in = 1'b1;
                        pass2_in      = 1'b0;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end

         S_READ: begin
            res_value_in  = ram_rd_data;
            res_freed_in  = '0;
            res_status_in = ST_OK;
            state_in      = S_RESP;
         end

         S_SCAN: begin
            ram_rd_addr = scan_addr_ff[AW-1:0];
            chk_in      = more;
            if (more) begin
               scan_addr_in = scan_addr_ff + SW'(1);
            end
            if (!scan_alloc_ff) begin
               if (hit) begin
                  res_value_in  = CLUSTER_W'(cand);
                  res_status_in = ST_OK;
                  state_in      = S_RESP;
               end else if (exhausted) begin
                  res_value_in  = '0;
                  res_status_in = ST_NOSPACE;
                  state_in      = S_RESP;
               end
            end else if (!pass2_ff) begin
               // first pass only counts, so a short table leaves nothing changed
               if (hit) begin
                  if (got_ff == '0) begin
                     first_in = cand;
                  end
                  if (got_nxt == need_ff) begin
                     pass2_in     = 1'b1;
                     got_in       = '0;
                     scan_addr_in = (got_ff == '0) ? cand : first_ff;
                     chk_in       = 1'b0;
                  end else begin
                     got_in = got_nxt;
                  end
               end else if (exhausted) begin
                  res_value_in  = '0;
                  res_status_in = ST_NOSPACE;
                  state_in      = S_RESP;
               end
            end else begin
               // second pass links the free cluster found before each hit to that hit
               if (hit) begin
                  if (got_ff != '0) begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = CLUSTER_W'(prev_ff);
                     ram_wr.data = CLUSTER_W'(cand);
                  end
                  prev_in = cand;
                  got_in  = got_nxt;
                  if (got_nxt == need_ff) begin
                     state_in = S_END_WR;
                  end
               end else if (exhausted) begin
                  state_in = S_END_WR;
               end
            end
            res_freed_in = '0;
         end

         S_END_WR: begin
            ram_wr.en     = 1'b1;
            ram_wr.addr   = CLUSTER_W'(prev_ff);
            ram_wr.data   = LINK_END;
            res_value_in  = CLUSTER_W'(first_ff);
            res_freed_in  = '0;
            res_status_in = ST_OK;
            state_in      = S_RESP;
         end

         S_WALK_RD: begin
            ram_rd_addr  = cur_ff[AW-1:0];
            res_value_in = '0;
            res_freed_in = freed_ff[FREED_W-1:0];
            if (cur_ff < 16'd2 || cur_ff >= END_FROM) begin
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end else if ({1'b0, cur_ff} >= 17'(NUM_CLUSTERS)) begin
               res_status_in = ST_OUT;
               state_in      = S_RESP;
            end else begin
               state_in = S_WALK_WR;
            end
         end

         S_WALK_WR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cur_ff;
            ram_wr.data = LINK_FREE;
            freed_in    = freed_nxt;
            if (freed_nxt > FCW'(FREE_LIMIT)) begin
               res_value_in  = '0;
               res_freed_in  = freed_nxt[FREED_W-1:0];
               res_status_in = ST_LOOP;
               state_in      = S_RESP;
            end else begin
               cur_in   = ram_rd_data;
               state_in = S_WALK_RD;
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_freed_in  = res_freed_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff  <= scan_addr_in;
      chk_ff        <= chk_in;
      scan_alloc_ff <= scan_alloc_in;
      pass2_ff      <= pass2_in;
      need_ff       <= need_in;
      got_ff        <= got_in;
      first_ff      <= first_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      freed_ff      <= freed_in;
      res_value_ff  <= res_value_in;
      res_freed_ff  <= res_freed_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_freed_count  = rsp_freed_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

@@ hw/rtl/fat16cct_link_ram.sv @@
// Single-port-write, registered-read link table memory.
module fat16cct_link_ram #(
   parameter int DEPTH = fat16cct_pkg::NUM_CLUSTERS_DEF,
   parameter int AW    = $clog2(fat16cct_pkg::NUM_CLUSTERS_DEF)
) (
   input  logic                              clock,
   input  fat16cct_pkg::ram_wr_type          wr,
   input  logic [AW-1:0]                     rd_addr,
   output logic [fat16cct_pkg::LINK_W-1:0]   rd_data
);
   import fat16cct_pkg::*;

   logic [LINK_W-1:0] link_mem [DEPTH];
   logic [LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_mem[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_data_ff <= link_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/fat16cct_checker.sv @@
// Port-level checks for the cluster chain table unit, bound to the top level.
`include "fat16_cluster_chain_table_unit_macros.svh"

module fat16cct_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [fat16cct_pkg::CLUSTER_W-1:0]  rsp_result_value,
   input logic [fat16cct_pkg::FREED_W-1:0]    rsp_freed_count,
   input logic [fat16cct_pkg::STATUS_W-1:0]   rsp_status
);
   import fat16cct_pkg::*;

   // result held while stalled
   `FAT16CCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status), "result changed while stalled")

   // clearing pass keeps requests out right after reset
   `FAT16CCT_ASSERT_NEXT(a_clear_busy, clock, 1'b0, reset, !req_ready, "request taken during clearing pass")

   // one request at a time
   `FAT16CCT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "second request taken while busy")

   // freed clusters only come with a chain walk outcome
   `FAT16CCT_ASSERT_NOW(a_freed_status, clock, reset, rsp_valid && rsp_freed_count != '0, rsp_status == ST_OK || rsp_status == ST_OUT || rsp_status == ST_LOOP, "freed count with wrong status")

   // no space never names a cluster
   `FAT16CCT_ASSERT_NOW(a_nospace_zero, clock, reset, rsp_valid && rsp_status == ST_NOSPACE, rsp_result_value == '0, "no-space result carries a cluster")

endmodule

bind fat16_cluster_chain_table_unit fat16cct_checker u_fat16cct_checker (.*);

@@ tb/sv/fat16_cluster_chain_table_unit_tb.sv @@
// Self-checking testbench for the FAT16 cluster chain table unit.
`timescale 1ns / 1ps

module fat16_cluster_chain_table_unit_tb;
   import fat16cct_pkg::*;

   localparam int TABLE_DEPTH    = NUM_CLUSTERS_DEF;
   localparam int SLOWEST_OP     = 2 * TABLE_DEPTH + 8;
   localparam int WATCHDOG_LIMIT = 4 * (SLOWEST_OP + TABLE_DEPTH + 64);
   localparam int RANDOM_ITEMS   = 20;

   typedef struct packed {
      logic [CLUSTER_W-1:0] value;
      logic [FREED_W-1:0]   freed;
      logic [STATUS_W-1:0]  status;
   } table_result_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_operation  = '0;
   logic [CLUSTER_W-1:0] req_cluster    = '0;
   logic [LINK_W-1:0]    req_link_value = '0;
   logic [COUNT_W-1:0]   req_count      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [CLUSTER_W-1:0] rsp_result_value;
   logic [FREED_W-1:0]   rsp_freed_count;
   logic [STATUS_W-1:0]  rsp_status;

   // mirror of the link memory, and the results still owed by the block
   logic [LINK_W-1:0]    link_mirror [0:TABLE_DEPTH-1];
   table_result_type     pending_results [$];
   table_result_type     last_predicted;
   int                   fault_count    = 0;
   int                   quiet_cycles   = 0;
   bit                   req_idle_on    = 1'b1;
   bit                   rsp_idle_on    = 1'b1;

   fat16_cluster_chain_table_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_cluster      (req_cluster),
      .req_link_value   (req_link_value),
      .req_count        (req_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_freed_count  (rsp_freed_count),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) link_mirror[i] = LINK_FREE;
   end

   // Applies one request to the mirror and returns the result it should give.
   function automatic table_result_type apply_table_op(input logic [OP_W-1:0] op,
                                                       input logic [CLUSTER_W-1:0] cl,
                                                       input logic [LINK_W-1:0] lv,
                                                       input logic [COUNT_W-1:0] cnt);
      table_result_type r;
      int unsigned   cur;
      int unsigned   nxt;
      int unsigned   freed;
      int unsigned   need;
      logic [STATUS_W-1:0] st;
      int unsigned   picked [$];
      r = '{LINK_FREE, '0, ST_OK};
      case (op)
         OP_READ_NEXT: begin
            if (cl < 2 || cl >= RESERVED_FROM) r = '{LINK_END, '0, ST_RESERVED};
            else if (cl >= TABLE_DEPTH) r = '{LINK_END, '0, ST_OUT};
            else r = '{link_mirror[cl], '0, ST_OK};
         end
         OP_SET_ENTRY: begin
            if (cl < 2) r.status = ST_RESERVED;
            else if (cl >= TABLE_DEPTH) r.status = ST_OUT;
            else link_mirror[cl] = lv;
         end
         OP_FIND_FREE: begin
            r.status = ST_NOSPACE;
            for (int i = 2; i < TABLE_DEPTH; i++) begin
               if (link_mirror[i] == LINK_FREE) begin
                  r = '{CLUSTER_W'(i), '0, ST_OK};
                  break;
               end
            end
         end
         OP_FREE_CHAIN: begin
            if (cl < 2) begin
               r.status = ST_RESERVED;
            end else begin
               cur   = 32'(cl);
               freed = 0;
               st    = ST_OK;
               while (cur >= 2 && cur < END_FROM) begin
                  if (cur >= TABLE_DEPTH) begin
                     st = ST_OUT;
                     break;
                  end
                  nxt = 32'(link_mirror[cur]);
                  link_mirror[cur] = LINK_FREE;
                  freed++;
                  if (freed > FREE_LIMIT_DEF) begin
                     st = ST_LOOP;
                     break;
                  end
                  cur = nxt;
               end
               r = '{LINK_FREE, FREED_W'(freed), st};
            end
         end
         OP_ALLOC_CHAIN: begin
            need = (cnt == '0) ? 1 : 32'(cnt);
            r.status = ST_NOSPACE;
            if (need <= MAX_CHAIN_DEF) begin
               for (int i = 2; i < TABLE_DEPTH && picked.size() < need; i++)
                  if (link_mirror[i] == LINK_FREE) picked.push_back(i);
               if (picked.size() == need) begin
                  for (int k = 0; k < need; k++)
                     link_mirror[picked[k]] = (k == need - 1) ? LINK_END
                                                             : LINK_W'(picked[k+1]);
                  r = '{CLUSTER_W'(picked[0]), '0, ST_OK};
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int count_free();
      int n;
      n = 0;
      for (int i = 2; i < TABLE_DEPTH; i++)
         if (link_mirror[i] == LINK_FREE) n++;
      return n;
   endfunction

   task automatic issue_request(input logic [OP_W-1:0] op, input logic [CLUSTER_W-1:0] cl,
                                input logic [LINK_W-1:0] lv, input logic [COUNT_W-1:0] cnt);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(19, 0) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_cluster    <= cl;
      req_link_value <= lv;
      req_count      <= cnt;
      do @(posedge clock); while (req_ready !== 1'b1);
      last_predicted = apply_table_op(op, cl, lv, cnt);
      pending_results.push_back(last_predicted);
   endtask

   // result side: random stall before each result is taken
   always begin
      int unsigned stall;
      stall = rsp_idle_on ? $urandom_range(19, 0) : 0;
      @(negedge clock);
      if (stall != 0) begin
         rsp_ready <= 1'b0;
         repeat (stall) @(negedge clock);
      end
      rsp_ready <= 1'b1;
      do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready === 1'b1));
   end

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding");
            fault_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("result_value", want.value, rsp_result_value);
            compare_field("freed_count", 16'(want.freed), 16'(rsp_freed_count));
            compare_field("status", 16'(want.status), 16'(rsp_status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_bounds_and_reserved();
      issue_request(OP_READ_NEXT, 16'h0000, '0, '0);
      issue_request(OP_READ_NEXT, 16'h0001, '1, '1);
      issue_request(OP_READ_NEXT, RESERVED_FROM, '0, '0);
      issue_request(OP_READ_NEXT, 16'hFFF7, '0, '0);
      issue_request(OP_READ_NEXT, 16'hFFFF, '0, '0);
      issue_request(OP_READ_NEXT, CLUSTER_W'(TABLE_DEPTH), '0, '0);
      issue_request(OP_READ_NEXT, 16'hFFEF, '0, '0);
      issue_request(OP_READ_NEXT, CLUSTER_W'(TABLE_DEPTH - 1), '0, '0);
      issue_request(OP_SET_ENTRY, 16'h0000, 16'h1234, '0);
      issue_request(OP_SET_ENTRY, 16'h0001, LINK_END, '0);
      issue_request(OP_SET_ENTRY, CLUSTER_W'(TABLE_DEPTH), 16'h0002, '0);
      issue_request(OP_SET_ENTRY, 16'hFFFF, 16'h0002, '0);
      issue_request(OP_FREE_CHAIN, 16'h0000, '0, '0);
      issue_request(OP_FREE_CHAIN, 16'h0001, '0, '0);
   endtask

   task automatic test_link_walks();
      issue_request(OP_SET_ENTRY, 16'h0002, LINK_END, '0);
      issue_request(OP_SET_ENTRY, CLUSTER_W'(TABLE_DEPTH - 1), 16'hA5A5, '0);
      issue_request(OP_READ_NEXT, CLUSTER_W'(TABLE_DEPTH - 1), '0, '0);
      issue_request(OP_READ_NEXT, 16'h0002, '0, '0);
      issue_request(OP_SET_ENTRY, 16'h0009, 16'h5A5A, '0);
      issue_request(OP_READ_NEXT, 16'h0009, '0, '0);
      issue_request(OP_FIND_FREE, '0, '0, '0);
      // chain stopped by an end-range marker below 0xFFFF
      issue_request(OP_SET_ENTRY, 16'h0005, 16'h0006, '0);
      issue_request(OP_SET_ENTRY, 16'h0006, END_FROM, '0);
      issue_request(OP_FREE_CHAIN, 16'h0005, '0, '0);
      // link pointing past the table
      issue_request(OP_SET_ENTRY, 16'h0007, 16'h1234, '0);
      issue_request(OP_FREE_CHAIN, 16'h0007, '0, '0);
      issue_request(OP_FREE_CHAIN, 16'h0008, '0, '0);
      issue_request(OP_FREE_CHAIN, CLUSTER_W'(TABLE_DEPTH), '0, '0);
      issue_request(OP_FREE_CHAIN, 16'hFFFF, '0, '0);
      issue_request(OP_FREE_CHAIN, CLUSTER_W'(TABLE_DEPTH - 1), '0, '0);
   endtask

   task automatic test_alloc_limits();
      logic [CLUSTER_W-1:0] head;
      issue_request(OP_ALLOC_CHAIN, '0, '0, '0);
      issue_request(OP_ALLOC_CHAIN, '1, '1, 7'd1);
      issue_request(OP_ALLOC_CHAIN, '0, '0, COUNT_W'(MAX_CHAIN_DEF));
      head = last_predicted.value;
      issue_request(OP_READ_NEXT, head, '0, '0);
      issue_request(OP_ALLOC_CHAIN, '0, '0, COUNT_W'(MAX_CHAIN_DEF + 1));
      issue_request(OP_ALLOC_CHAIN, '0, '0, '1);
      issue_request(OP_FREE_CHAIN, head, '0, '0);
   endtask

   task automatic test_unknown_ops();
      for (int k = int'(OP_ALLOC_CHAIN) + 1; k < 2**OP_W; k++)
         issue_request(OP_W'(k), '1, '1, '1);
   endtask

   // Fills the table, then joins chains into one longer than the walk limit.
   task automatic test_full_table();
      int unsigned heads [$];
      int unsigned n;
      int unsigned tail;
      int unsigned rest;
      while (count_free() != 0) begin
         n = count_free();
         if (n > MAX_CHAIN_DEF) n = MAX_CHAIN_DEF;
         issue_request(OP_ALLOC_CHAIN, 16'($urandom), 16'($urandom), COUNT_W'(n));
         heads.push_back(32'(last_predicted.value));
      end
      issue_request(OP_FIND_FREE, '0, '0, '0);
      issue_request(OP_ALLOC_CHAIN, '0, '0, '0);
      issue_request(OP_ALLOC_CHAIN, '0, '0, 7'd2);
      for (int k = 0; k < 10; k++) begin
         tail = heads[k];
         while (link_mirror[tail] != LINK_END) tail = 32'(link_mirror[tail]);
         issue_request(OP_SET_ENTRY, CLUSTER_W'(tail), LINK_W'(heads[k+1]), '0);
      end
      rest = heads[0];
      repeat (FREE_LIMIT_DEF + 1) rest = 32'(link_mirror[rest]);
      issue_request(OP_FREE_CHAIN, CLUSTER_W'(heads[0]), '0, '0);
      issue_request(OP_FREE_CHAIN, CLUSTER_W'(rest), '0, '0);
      for (int k = 11; k < heads.size(); k++)
         issue_request(OP_FREE_CHAIN, CLUSTER_W'(heads[k]), '0, '0);
   endtask

   task automatic test_random_traffic();
      int unsigned live_heads [$];
      int unsigned pick;
      int unsigned idx;
      logic [CLUSTER_W-1:0] cl;
      logic [LINK_W-1:0]    lv;
      logic [COUNT_W-1:0]   cnt;
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         if ($urandom_range(15, 0) == 0) req_idle_on = !req_idle_on;
         if ($urandom_range(15, 0) == 0) rsp_idle_on = !rsp_idle_on;
         pick = $urandom_range(99, 0);
         cl   = 16'($urandom);
         lv   = 16'($urandom);
         cnt  = 7'($urandom);
         if (pick < 25) begin
            if ($urandom_range(7, 0) != 0) cnt = COUNT_W'($urandom_range(8, 1));
            issue_request(OP_ALLOC_CHAIN, cl, lv, cnt);
            if (last_predicted.status == ST_OK)
               live_heads.push_back(32'(last_predicted.value));
         end else if (pick < 40) begin
            if (live_heads.size() != 0) begin
               idx = $urandom_range(live_heads.size() - 1, 0);
               cl  = CLUSTER_W'(live_heads[idx]);
               live_heads.delete(idx);
            end else begin
               cl = CLUSTER_W'($urandom_range(320, 0));
            end
            issue_request(OP_FREE_CHAIN, cl, lv, cnt);
         end else if (pick < 55) begin
            if ($urandom_range(3, 0) != 0) cl = CLUSTER_W'($urandom_range(320, 0));
            issue_request(OP_READ_NEXT, cl, lv, cnt);
         end else if (pick < 70) begin
            if ($urandom_range(3, 0) != 0) cl = CLUSTER_W'($urandom_range(320, 2));
            case ($urandom_range(3, 0))
               0: lv = LINK_FREE;
               1: lv = LINK_END;
               2: lv = LINK_W'($urandom_range(320, 2));
               default: ;
            endcase
            issue_request(OP_SET_ENTRY, cl, lv, cnt);
         end else if (pick < 80) begin
            issue_request(OP_FIND_FREE, cl, lv, cnt);
         end else if (pick < 90) begin
            if ($urandom_range(1, 0) != 0) cl = CLUSTER_W'($urandom_range(320, 0));
            issue_request(OP_FREE_CHAIN, cl, lv, cnt);
         end else begin
            issue_request(OP_W'($urandom_range(2**OP_W - 1, 0)), cl, lv, cnt);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_bounds_and_reserved();
      test_link_walks();
      test_alloc_limits();
      test_unknown_ops();
      test_full_table();
      test_random_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // room for a stray extra result from the slowest operation
      repeat (SLOWEST_OP) @(posedge clock);
      if (fault_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
